/* hw/rtl/assert_macros.svh */
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that holds also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/sil_pkg.sv */
// Package for the sorted insert list: field widths, cell command and result packing.
`timescale 1ns / 1ps
package sil_pkg;

   localparam int VALUE_W    = 32;
   localparam int POS_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - VALUE_W - POS_W - COUNT_W;

   typedef struct packed {
      logic                       insert;
      logic                       rotate;
      logic signed [VALUE_W-1:0]  key;
   } sil_cmd_type;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic [VALUE_W-1:0] value,
      input logic [POS_W-1:0]   pos,
      input logic [COUNT_W-1:0] count
   );
      pack_rsp = {{RSP_PAD_W{1'b0}}, count, pos, value};
   endfunction

endpackage

/* hw/rtl/sil_cell.sv */
// One cell of the sorted chain: holds a value, compares it with the key and shifts.
`timescale 1ns / 1ps
module sil_cell (
   input  logic                                  clock,
   input  sil_pkg::sil_cmd_type                  cmd,
   input  logic signed [sil_pkg::VALUE_W-1:0]    left_value,
   input  logic                                  left_gt,
   input  logic signed [sil_pkg::VALUE_W-1:0]    right_value,
   input  logic signed [sil_pkg::VALUE_W-1:0]    head_value,
   input  logic                                  is_valid,
   input  logic                                  is_tail,
   output logic signed [sil_pkg::VALUE_W-1:0]    value,
   output logic                                  gt
);
   import sil_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   assign gt    = !is_valid || (value_ff > cmd.key);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.insert && gt) begin
         value_in = left_gt ? left_value : cmd.key;
      end else if (cmd.rotate) begin
         value_in = is_tail ? head_value : right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* hw/rtl/sorted_insert_list.sv */
// Top level of the sorted insert list: cell chain, entry count and result sequencing.
//
//   channel  dir  tdata                          tuser                   tlast
//   req      in   value[31:0]                    command[0]              -
//   rsp      out  item_value, position, count    empty_res, overflow     last
//
// On an insert every cell compares with the key at once and the chain shifts
// right from the insertion point. A read-out emits one value per cycle while the
// result is not stalled, by rotating the chain towards cell 0.
// Reset clears the count and the control state; cell contents stay as they are.
// A stalled result holds the chain; no new item is taken until it is free.
`timescale 1ns / 1ps
module sorted_insert_list #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sil_pkg::REQ_DATA_W-1:0]     req_tdata,  // value[31:0]
   input  logic [0:0]                         req_tuser,  // command[0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sil_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // item_value[31:0], position[37:32], count[44:38]
   output logic                               rsp_tlast,
   output logic [1:0]                         rsp_tuser   // empty_res[0], overflow[1]
);
   import sil_pkg::*;

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type                state_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic [POS_W-1:0]         idx_ff;
   logic                     rsp_tvalid_ff;
   logic                     rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]    rsp_tdata_ff;
   logic                     rsp_tlast_ff;
   logic [1:0]               rsp_tuser_ff;

   logic                     slot_free;
   logic                     accept;
   logic                     full;
   logic                     read_last;
   sil_cmd_type              cmd;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]      cell_gt;
   logic [CAPACITY-1:0]      ins_hit;
   logic [POS_W-1:0]         ins_pos;

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = count_ff == COUNT_W'(CAPACITY);
   assign read_last  = (COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff;

   assign cmd.insert = accept && !req_tuser[0] && !full;
   assign cmd.rotate = (state_ff == ST_READ) && slot_free;
   assign cmd.key    = req_tdata;

   assign rsp_tvalid_in = (accept && !(req_tuser[0] && (count_ff != '0))) || cmd.rotate ||
                          (rsp_tvalid_ff && !rsp_tready);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic                      left_gt;
      logic signed [VALUE_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_value = req_tdata;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_value = cell_value[0];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      assign ins_hit[i] = cell_gt[i] && !left_gt;

      sil_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .head_value  (cell_value[0]),
         .is_valid    (count_ff > COUNT_W'(i)),
         .is_tail     (count_ff == COUNT_W'(i + 1)),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ins_hit[i]) begin
            ins_pos = ins_pos | POS_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tdata_ff  <= '0;
         rsp_tlast_ff  <= 1'b0;
         rsp_tuser_ff  <= '0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (!req_tuser[0]) begin
                     rsp_tlast_ff  <= 1'b1;
                     if (full) begin
                        rsp_tdata_ff <= pack_rsp('0, '0, count_ff);
                        rsp_tuser_ff <= 2'b10;
                     end else begin
                        rsp_tdata_ff <= pack_rsp('0, ins_pos, count_ff + COUNT_W'(1));
                        rsp_tuser_ff <= 2'b00;
                        count_ff     <= count_ff + COUNT_W'(1);
                     end
                  end else if (count_ff == '0) begin
                     rsp_tlast_ff  <= 1'b1;
                     rsp_tdata_ff  <= pack_rsp('0, '0, '0);
                     rsp_tuser_ff  <= 2'b01;
                  end else begin
                     state_ff <= ST_READ;
                     idx_ff   <= '0;
                  end
               end
            end
            ST_READ: begin
               if (slot_free) begin
                  rsp_tdata_ff  <= pack_rsp(cell_value[0], idx_ff, count_ff);
                  rsp_tuser_ff  <= 2'b00;
                  rsp_tlast_ff  <= read_last;
                  if (read_last) begin
                     state_ff <= ST_IDLE;
                     idx_ff   <= '0;
                  end else begin
                     idx_ff <= idx_ff + POS_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* hw/rtl/sil_checker.sv */
// Port checker for the sorted insert list, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sil_checker #(
   parameter int CAPACITY = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sil_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tlast,
   input logic [1:0]                         rsp_tuser
);
   import sil_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")
   `ASSERT_CLK(a_flag_last, clock, reset, rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]) |-> rsp_tlast && !(rsp_tuser[0] && rsp_tuser[1]), "flagged item not single and last")
   `ASSERT_CLK(a_empty_zero, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[44:38] == '0, "empty item with nonzero count")
   `ASSERT_CLK(a_readout_block, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready, "request taken during read-out")
   `ASSERT_CLK(a_count_cap, clock, reset, rsp_tvalid |-> rsp_tdata[44:38] <= COUNT_W'(CAPACITY), "count above capacity")

endmodule

bind sorted_insert_list sil_checker #(.CAPACITY(CAPACITY)) u_sil_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
